### hdl/framed_key_value_tokenizer_macros.svh
// Assertion macros for the tokenizer RTL, used by the output side (ftk_back).
// Each macro takes a label, clock, active-low reset, the two terms and a message.
`ifndef FRAMED_KEY_VALUE_TOKENIZER_MACROS_SVH
`define FRAMED_KEY_VALUE_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define FTK_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define FTK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ftk_pkg.sv
// Shared types and constants of the key/value tokenizer.
// No dependencies; used by every module of the block.
package ftk_pkg;

    // Default number of result bundles held between parser and output
    localparam int unsigned QUEUE_DEPTH = 4;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_IGNORE_A  = 3'd0,
        REG_IGNORE_B  = 3'd1,
        REG_IGNORE_C  = 3'd2,
        REG_IGNORE_D  = 3'd3,
        REG_OPEN      = 3'd4,
        REG_CLOSE     = 3'd5,
        REG_KEY_DIV   = 3'd6,
        REG_PAIR_DIV  = 3'd7
    } reg_index_t;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_IGNORE_A = 8'd32;
    localparam logic [7:0] RST_IGNORE_B = 8'd9;
    localparam logic [7:0] RST_IGNORE_C = 8'd13;
    localparam logic [7:0] RST_IGNORE_D = 8'd10;
    localparam logic [7:0] RST_OPEN     = 8'd60;
    localparam logic [7:0] RST_CLOSE    = 8'd62;
    localparam logic [7:0] RST_KEY_DIV  = 8'd58;
    localparam logic [7:0] RST_PAIR_DIV = 8'd44;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_KEY  = 3'd0,
        KIND_VAL  = 3'd1,
        KIND_PAIR = 3'd2,
        KIND_ERR  = 3'd3,
        KIND_END  = 3'd4
    } kind_t;

    // Parser phases
    typedef enum logic [2:0] {
        PH_SKIP      = 3'd0,
        PH_KEY       = 3'd1,
        PH_WANT_KDIV = 3'd2,
        PH_VAL_START = 3'd3,
        PH_VAL       = 3'd4,
        PH_WANT_PDIV = 3'd5,
        PH_ERROR     = 3'd6
    } phase_t;

    // Results caused by one input byte: an optional own result and an
    // optional buffer-end marker behind it
    typedef struct packed {
        logic       has_main;
        kind_t      main_kind;
        logic [7:0] main_byte;
        logic       has_end;
    } bundle_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### hdl/ftk_front.sv
// Front end of the tokenizer: configuration registers and the parser state machine.
// Classifies each accepted byte into a result bundle. Depends on ftk_pkg.
module ftk_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  logic                in_end,
    input  ftk_pkg::q_status_t  q_status,
    output logic                push,
    output ftk_pkg::bundle_t    push_bundle
);

    logic [7:0] ignore_a_reg;
    logic [7:0] ignore_b_reg;
    logic [7:0] ignore_c_reg;
    logic [7:0] ignore_d_reg;
    logic [7:0] open_reg;
    logic [7:0] close_reg;
    logic [7:0] key_div_reg;
    logic [7:0] pair_div_reg;

    ftk_pkg::phase_t  phase_reg;
    ftk_pkg::phase_t  phase_next;
    logic [7:0]       value_close_reg;
    logic [7:0]       value_close_next;

    logic             accept;
    logic             ignored;
    logic [7:0]       key_close;
    ftk_pkg::bundle_t bundle;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignore_a_reg <= ftk_pkg::RST_IGNORE_A;
            ignore_b_reg <= ftk_pkg::RST_IGNORE_B;
            ignore_c_reg <= ftk_pkg::RST_IGNORE_C;
            ignore_d_reg <= ftk_pkg::RST_IGNORE_D;
            open_reg     <= ftk_pkg::RST_OPEN;
            close_reg    <= ftk_pkg::RST_CLOSE;
            key_div_reg  <= ftk_pkg::RST_KEY_DIV;
            pair_div_reg <= ftk_pkg::RST_PAIR_DIV;
        end
        else if (cfg_write)
        begin
            case (ftk_pkg::reg_index_t'(cfg_index))
                ftk_pkg::REG_IGNORE_A: ignore_a_reg <= cfg_data;
                ftk_pkg::REG_IGNORE_B: ignore_b_reg <= cfg_data;
                ftk_pkg::REG_IGNORE_C: ignore_c_reg <= cfg_data;
                ftk_pkg::REG_IGNORE_D: ignore_d_reg <= cfg_data;
                ftk_pkg::REG_OPEN:     open_reg     <= cfg_data;
                ftk_pkg::REG_CLOSE:    close_reg    <= cfg_data;
                ftk_pkg::REG_KEY_DIV:  key_div_reg  <= cfg_data;
                ftk_pkg::REG_PAIR_DIV: pair_div_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Take a byte whenever the queue has room
    assign accept = in_valid && !q_status.full;

    // Match against the enabled ignore characters
    assign ignored = (ignore_a_reg != 8'd0 && in_byte == ignore_a_reg) ||
                     (ignore_b_reg != 8'd0 && in_byte == ignore_b_reg) ||
                     (ignore_c_reg != 8'd0 && in_byte == ignore_c_reg) ||
                     (ignore_d_reg != 8'd0 && in_byte == ignore_d_reg);

    // The key ends at the close frame, or at the key divider when unframed
    assign key_close = (close_reg != 8'd0) ? close_reg : key_div_reg;

    // Advance the parser and build the result bundle
    always_comb
    begin
        phase_next       = phase_reg;
        value_close_next = value_close_reg;
        bundle           = '{has_main: 1'b0, main_kind: ftk_pkg::KIND_KEY,
                             main_byte: 8'd0, has_end: 1'b0};
        case (phase_reg)
            ftk_pkg::PH_SKIP:
            begin
                if (!ignored)
                begin
                    if (open_reg != 8'd0)
                    begin
                        if (in_byte == open_reg)
                        begin
                            phase_next = ftk_pkg::PH_KEY;
                        end
                        else
                        begin
                            bundle.has_main  = 1'b1;
                            bundle.main_kind = ftk_pkg::KIND_ERR;
                            phase_next       = ftk_pkg::PH_ERROR;
                        end
                    end
                    else if (in_byte == key_close)
                    begin
                        phase_next = (key_close != key_div_reg) ? ftk_pkg::PH_WANT_KDIV
                                                                : ftk_pkg::PH_VAL_START;
                    end
                    else
                    begin
                        bundle.has_main  = 1'b1;
                        bundle.main_byte = in_byte;
                        phase_next       = ftk_pkg::PH_KEY;
                    end
                end
            end
            ftk_pkg::PH_KEY:
            begin
                if (in_byte == key_close)
                begin
                    phase_next = (key_close != key_div_reg) ? ftk_pkg::PH_WANT_KDIV
                                                            : ftk_pkg::PH_VAL_START;
                end
                else
                begin
                    bundle.has_main  = 1'b1;
                    bundle.main_byte = in_byte;
                end
            end
            ftk_pkg::PH_WANT_KDIV:
            begin
                if (in_byte == key_div_reg)
                begin
                    phase_next = ftk_pkg::PH_VAL_START;
                end
                else
                begin
                    bundle.has_main  = 1'b1;
                    bundle.main_kind = ftk_pkg::KIND_ERR;
                    phase_next       = ftk_pkg::PH_ERROR;
                end
            end
            ftk_pkg::PH_VAL_START:
            begin
                phase_next = ftk_pkg::PH_VAL;
                if (open_reg != 8'd0 && in_byte == open_reg)
                begin
                    value_close_next = (close_reg != 8'd0) ? close_reg : pair_div_reg;
                end
                else
                begin
                    // Unframed value: the pair divider closes it, this byte may already
                    value_close_next = pair_div_reg;
                    bundle.has_main  = 1'b1;
                    if (in_byte == pair_div_reg)
                    begin
                        bundle.main_kind = ftk_pkg::KIND_PAIR;
                        phase_next       = ftk_pkg::PH_SKIP;
                    end
                    else
                    begin
                        bundle.main_kind = ftk_pkg::KIND_VAL;
                        bundle.main_byte = in_byte;
                    end
                end
            end
            ftk_pkg::PH_VAL:
            begin
                bundle.has_main = 1'b1;
                if (in_byte == value_close_reg)
                begin
                    bundle.main_kind = ftk_pkg::KIND_PAIR;
                    phase_next = (value_close_reg != pair_div_reg) ? ftk_pkg::PH_WANT_PDIV
                                                                   : ftk_pkg::PH_SKIP;
                end
                else
                begin
                    bundle.main_kind = ftk_pkg::KIND_VAL;
                    bundle.main_byte = in_byte;
                end
            end
            ftk_pkg::PH_WANT_PDIV:
            begin
                if (in_byte == pair_div_reg)
                begin
                    phase_next = ftk_pkg::PH_SKIP;
                end
                else
                begin
                    bundle.has_main  = 1'b1;
                    bundle.main_kind = ftk_pkg::KIND_ERR;
                    phase_next       = ftk_pkg::PH_ERROR;
                end
            end
            default:
            begin
                // Error phase and unused codes: drop the byte
                phase_next = phase_reg;
            end
        endcase

        // Buffer end: append the marker and drop any unfinished pair
        if (in_end)
        begin
            bundle.has_end   = 1'b1;
            phase_next       = ftk_pkg::PH_SKIP;
            value_close_next = 8'd0;
        end
    end

    // Hold parser state between accepted bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ftk_pkg::PH_SKIP;
            value_close_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            value_close_reg <= value_close_next;
        end
    end

    // Queue only bytes that cause a result
    assign push        = accept && (bundle.has_main || bundle.has_end);
    assign push_bundle = bundle;

endmodule

### hdl/ftk_queue.sv
// Short queue of result bundles between the parser and the output side.
// Flip-flop storage read at the head pointer. Depends on ftk_pkg.
module ftk_queue
#(
    parameter int unsigned DEPTH = ftk_pkg::QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ftk_pkg::bundle_t   push_bundle,
    input  logic               pop,
    output ftk_pkg::bundle_t   head_bundle,
    output ftk_pkg::q_status_t q_status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ftk_pkg::bundle_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming bundle
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_bundle;
        end
    end

    assign head_bundle    = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_FULL);
    assign q_status.empty = (count_reg == '0);

endmodule

### hdl/ftk_back.sv
// Output side of the tokenizer: unpacks queued bundles into single results.
// Drives the registered output channel. Depends on ftk_pkg and the macro header.
`include "framed_key_value_tokenizer_macros.svh"

module ftk_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  ftk_pkg::bundle_t   head_bundle,
    input  ftk_pkg::q_status_t q_status,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         out_kind,
    output logic [7:0]         out_byte,
    output logic               out_last
);

    logic            out_valid_reg;
    logic            out_valid_next;
    ftk_pkg::kind_t  out_kind_reg;
    ftk_pkg::kind_t  out_kind_next;
    logic [7:0]      out_byte_reg;
    logic [7:0]      out_byte_next;
    logic            out_last_reg;
    logic            out_last_next;
    logic            pending_end_reg;
    logic            pending_end_next;
    logic            load;

    // The output register can take a new result when empty or being taken
    assign load = !out_valid_reg || !out_stall;

    // Pick the next result: a pending end marker first, then the queue head
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_kind_next    = out_kind_reg;
        out_byte_next    = out_byte_reg;
        out_last_next    = out_last_reg;
        pending_end_next = pending_end_reg;
        pop              = 1'b0;
        if (load)
        begin
            if (pending_end_reg)
            begin
                out_valid_next   = 1'b1;
                out_kind_next    = ftk_pkg::KIND_END;
                out_byte_next    = 8'd0;
                out_last_next    = 1'b1;
                pending_end_next = 1'b0;
            end
            else if (!q_status.empty)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                if (head_bundle.has_main)
                begin
                    out_kind_next    = head_bundle.main_kind;
                    out_byte_next    = head_bundle.main_byte;
                    out_last_next    = !head_bundle.has_end;
                    pending_end_next = head_bundle.has_end;
                end
                else
                begin
                    out_kind_next = ftk_pkg::KIND_END;
                    out_byte_next = 8'd0;
                    out_last_next = 1'b1;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            pending_end_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            pending_end_reg <= pending_end_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    // A pending end marker always sits behind a shown, non-final result
    `FTK_ASSERT_SAME(a_pending_shown, clk, rst_n, pending_end_reg, out_valid_reg && !out_last_reg, "pending end without a shown result")

    // A shown result that is not final always has its end marker pending
    `FTK_ASSERT_SAME(a_nonlast_pending, clk, rst_n, out_valid_reg && !out_last_reg, pending_end_reg, "non-final result without pending end")

    // Taking a result with an end pending shows the end marker next
    `FTK_ASSERT_NEXT(a_end_follows, clk, rst_n, out_valid_reg && !out_stall && pending_end_reg, out_valid_reg && out_kind_reg == ftk_pkg::KIND_END && out_last_reg, "end marker did not follow")

    // Never pop while the output is stalled and full
    `FTK_ASSERT_SAME(a_pop_load, clk, rst_n, pop, load && !q_status.empty && !pending_end_reg, "pop without room")

endmodule

### hdl/framed_key_value_tokenizer.sv
// Key/value tokenizer for a framed byte stream. The block accepts one byte per clock
// cycle as long as its result queue has room, and delivers one result per cycle while
// out_stall is low; a byte that causes two results (its own result and the buffer-end
// marker) delivers them in turn, bytes that cause no result deliver none, so sustained
// input rate is one byte per cycle whenever results average no more than one per byte.
// A byte's results pass through the queue and then the output register. A queue of
// QUEUE_DEPTH bundles between the parser and the output register absorbs output stalls;
// in_stall rises only when that queue is full. Configuration writes take effect at once
// and must be made while the block is idle. No clearing pass follows reset.
module framed_key_value_tokenizer
#(
    parameter int unsigned QUEUE_DEPTH = ftk_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] out_kind,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic               push;
    logic               pop;
    ftk_pkg::bundle_t   push_bundle;
    ftk_pkg::bundle_t   head_bundle;
    ftk_pkg::q_status_t q_status;

    // Parser
    ftk_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_byte     (in_byte),
        .in_end      (in_end),
        .q_status    (q_status),
        .push        (push),
        .push_bundle (push_bundle)
    );

    // Result queue
    ftk_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .pop         (pop),
        .head_bundle (head_bundle),
        .q_status    (q_status)
    );

    // Output side
    ftk_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_bundle (head_bundle),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_kind    (out_kind),
        .out_byte    (out_byte),
        .out_last    (out_last)
    );

    assign in_stall = q_status.full;

endmodule

### bench/framed_key_value_tokenizer_test.sv
// Self-checking testbench for the framed key/value tokenizer.
// Depends on ftk_pkg and framed_key_value_tokenizer; runs directed rows, then random buffers.
module framed_key_value_tokenizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ftk_pkg::*;

    // One expected result item
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    // One directed row: a register write or a byte request with optional typed results
    typedef struct packed {
        logic       is_cfg;
        reg_index_t idx;
        logic [7:0] data;
        logic       fin;
        logic       typed;
        logic [1:0] n;
        kind_t      k0;
        kind_t      k1;
    } row_t;

    localparam int NUM_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 115;

    // Directed rows, reset settings first, then framing switched off
    localparam row_t DIRECTED [29] = '{
        '{1'b0, REG_IGNORE_A, 8'h20, 1'b0, 1'b1, 2'd0, KIND_KEY,  KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'h3C, 1'b0, 1'b1, 2'd0, KIND_KEY,  KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'h61, 1'b0, 1'b1, 2'd1, KIND_KEY,  KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'h3E, 1'b0, 1'b1, 2'd0, KIND_KEY,  KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'h3A, 1'b0, 1'b1, 2'd0, KIND_KEY,  KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'h3C, 1'b0, 1'b1, 2'd0, KIND_KEY,  KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'hFF, 1'b0, 1'b1, 2'd1, KIND_VAL,  KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'h3E, 1'b0, 1'b1, 2'd1, KIND_PAIR, KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'h2C, 1'b0, 1'b1, 2'd0, KIND_KEY,  KIND_KEY},
        // missing opener, then the end marker behind it
        '{1'b0, REG_IGNORE_A, 8'h00, 1'b1, 1'b1, 2'd2, KIND_ERR,  KIND_END},
        '{1'b0, REG_IGNORE_A, 8'h3C, 1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'h3E, 1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
        // wrong byte where the key divider belongs
        '{1'b0, REG_IGNORE_A, 8'h3B, 1'b0, 1'b1, 2'd1, KIND_ERR,  KIND_KEY},
        // dropped in the error phase, only the end marker comes out
        '{1'b0, REG_IGNORE_A, 8'h3C, 1'b1, 1'b1, 2'd1, KIND_END,  KIND_KEY},
        // unframed value with framing on
        '{1'b0, REG_IGNORE_A, 8'h3C, 1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'h3E, 1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'h3A, 1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'h76, 1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'h2C, 1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
        // empty framed value, then no pair divider after its close
        '{1'b0, REG_IGNORE_A, 8'h3C, 1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'h3E, 1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'h3A, 1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'h3C, 1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'h3E, 1'b0, 1'b1, 2'd1, KIND_PAIR, KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'h78, 1'b1, 1'b1, 2'd2, KIND_ERR,  KIND_END},
        // no framing: the first byte may close the key at once
        '{1'b1, REG_OPEN,     8'h00, 1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
        '{1'b1, REG_CLOSE,    8'h00, 1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
        '{1'b0, REG_IGNORE_A, 8'h3A, 1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
        // unfinished value after the empty key, cut off by the buffer end
        '{1'b0, REG_IGNORE_A, 8'h80, 1'b1, 1'b1, 2'd2, KIND_VAL,  KIND_END}
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_end;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] out_kind;
    logic [7:0] out_byte;
    logic       out_last;

    // Parser state and register copy of the predictor
    logic [7:0] regs [8] = '{RST_IGNORE_A, RST_IGNORE_B, RST_IGNORE_C, RST_IGNORE_D,
                             RST_OPEN, RST_CLOSE, RST_KEY_DIV, RST_PAIR_DIV};
    phase_t     parse_phase = PH_SKIP;
    logic [7:0] value_close = 8'h00;

    result_t    expect_q [$];
    logic [7:0] frame_q [$];
    int         mismatches = 0;
    int         idle_pct   = 31;
    int         stall_pct  = 82;

    framed_key_value_tokenizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_end    (in_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Key byte: emit it, or close the key and pick the next phase
    function automatic logic key_char(input logic [7:0] b);
        logic [7:0] kclose;
        kclose = (regs[REG_CLOSE] != 8'h00) ? regs[REG_CLOSE] : regs[REG_KEY_DIV];
        if (b != kclose)
            return 1'b1;
        parse_phase = (kclose != regs[REG_KEY_DIV]) ? PH_WANT_KDIV : PH_VAL_START;
        return 1'b0;
    endfunction

    // Value byte: emit it, or mark the pair complete at its closing character
    function automatic kind_t val_char(input logic [7:0] b);
        if (b != value_close)
            return KIND_VAL;
        parse_phase = (value_close != regs[REG_PAIR_DIV]) ? PH_WANT_PDIV : PH_SKIP;
        return KIND_PAIR;
    endfunction

    // Advance the parser by one byte; return the results it causes
    function automatic int parse_byte(input logic [7:0] b, input logic fin,
                                      output result_t got [2]);
        logic  has;
        logic  skip;
        kind_t k;
        int    n;
        has = 1'b0;
        skip = 1'b0;
        k = KIND_ERR;
        n = 0;
        got[0] = '0;
        got[1] = '0;
        case (parse_phase)
            PH_SKIP:
            begin
                for (int i = 0; i < 4; i++)
                    if (regs[i] != 8'h00 && regs[i] == b)
                        skip = 1'b1;
                if (!skip)
                begin
                    if (regs[REG_OPEN] != 8'h00)
                    begin
                        if (b == regs[REG_OPEN])
                            parse_phase = PH_KEY;
                        else
                        begin
                            has = 1'b1;
                            parse_phase = PH_ERROR;
                        end
                    end
                    else
                    begin
                        parse_phase = PH_KEY;
                        has = key_char(b);
                        k = KIND_KEY;
                    end
                end
            end
            PH_KEY:
            begin
                has = key_char(b);
                k = KIND_KEY;
            end
            PH_WANT_KDIV:
            begin
                if (b == regs[REG_KEY_DIV])
                    parse_phase = PH_VAL_START;
                else
                begin
                    has = 1'b1;
                    parse_phase = PH_ERROR;
                end
            end
            PH_VAL_START:
            begin
                parse_phase = PH_VAL;
                if (regs[REG_OPEN] != 8'h00 && b == regs[REG_OPEN])
                    value_close = (regs[REG_CLOSE] != 8'h00) ? regs[REG_CLOSE]
                                                              : regs[REG_PAIR_DIV];
                else
                begin
                    value_close = regs[REG_PAIR_DIV];
                    has = 1'b1;
                    k = val_char(b);
                end
            end
            PH_VAL:
            begin
                has = 1'b1;
                k = val_char(b);
            end
            PH_WANT_PDIV:
            begin
                if (b == regs[REG_PAIR_DIV])
                    parse_phase = PH_SKIP;
                else
                begin
                    has = 1'b1;
                    parse_phase = PH_ERROR;
                end
            end
            default:
            begin
            end
        endcase
        if (has)
        begin
            got[0].kind = k;
            got[0].data = (k == KIND_KEY || k == KIND_VAL) ? b : 8'h00;
            n = 1;
        end
        // Buffer end: append the marker and drop any unfinished pair
        if (fin)
        begin
            got[n].kind = KIND_END;
            got[n].data = 8'h00;
            n++;
            parse_phase = PH_SKIP;
            value_close = 8'h00;
        end
        if (n > 0)
            got[n - 1].last = 1'b1;
        return n;
    endfunction

    // Random byte that matches no register
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        logic       hit;
        do
        begin
            b = 8'($urandom_range(255));
            hit = 1'b0;
            foreach (regs[i])
                if (regs[i] == b)
                    hit = 1'b1;
        end
        while (hit);
        return b;
    endfunction

    // Build one buffer of pairs for the current settings, sometimes broken or pure noise
    task automatic build_buffer();
        logic [7:0] kclose;
        logic [7:0] vclose;
        logic [7:0] ig;
        int         cut;
        frame_q.delete();
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 8))
                frame_q.push_back(8'($urandom_range(255)));
        end
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                repeat ($urandom_range(2))
                begin
                    ig = regs[$urandom_range(3)];
                    if (ig != 8'h00)
                        frame_q.push_back(ig);
                end
                if (regs[REG_OPEN] != 8'h00)
                    frame_q.push_back(regs[REG_OPEN]);
                repeat ($urandom_range(3))
                    frame_q.push_back(plain_byte());
                kclose = (regs[REG_CLOSE] != 8'h00) ? regs[REG_CLOSE] : regs[REG_KEY_DIV];
                frame_q.push_back(kclose);
                if (kclose != regs[REG_KEY_DIV])
                    frame_q.push_back(regs[REG_KEY_DIV]);
                if (regs[REG_OPEN] != 8'h00 && $urandom_range(1) == 1)
                begin
                    frame_q.push_back(regs[REG_OPEN]);
                    repeat ($urandom_range(3))
                        frame_q.push_back(plain_byte());
                    vclose = (regs[REG_CLOSE] != 8'h00) ? regs[REG_CLOSE] : regs[REG_PAIR_DIV];
                    frame_q.push_back(vclose);
                    if (vclose != regs[REG_PAIR_DIV])
                        frame_q.push_back(regs[REG_PAIR_DIV]);
                end
                else
                begin
                    repeat ($urandom_range(3))
                        frame_q.push_back(plain_byte());
                    frame_q.push_back(regs[REG_PAIR_DIV]);
                end
            end
            // Corrupt one byte or cut the buffer short now and then
            case ($urandom_range(7))
                0: frame_q[$urandom_range(frame_q.size() - 1)] = 8'($urandom_range(255));
                1:
                begin
                    cut = $urandom_range(1, frame_q.size());
                    while (frame_q.size() > cut)
                        void'(frame_q.pop_back());
                end
                default:
                begin
                end
            endcase
        end
    endtask

    // Offer one byte request, hold it until accepted, then predict its results
    task automatic send_byte(input logic [7:0] b, input logic fin, input logic use_model);
        result_t got [2];
        int      n;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_end   <= fin;
        do
            @(posedge clk);
        while (in_stall);
        n = parse_byte(b, fin, got);
        if (use_model)
            for (int j = 0; j < n; j++)
                expect_q.push_back(got[j]);
    endtask

    // Drop valid and wait until the block has drained
    task automatic settle();
        in_valid <= 1'b0;
        while (expect_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write one register while idle
    task automatic write_reg(input reg_index_t idx, input logic [7:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        regs[idx] = v;
    endtask

    // Stimulus
    initial
    begin
        row_t       row;
        result_t    res;
        logic [7:0] settings [8];
        int         sent;
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_byte   <= '0;
        in_end    <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows
        for (int r = 0; r < $size(DIRECTED); r++)
        begin
            row = DIRECTED[r];
            if (row.is_cfg)
            begin
                settle();
                write_reg(row.idx, row.data);
            end
            else
            begin
                send_byte(row.data, row.fin, !row.typed);
                if (row.typed)
                    for (int j = 0; j < int'(row.n); j++)
                    begin
                        res.kind = (j == 0) ? row.k0 : row.k1;
                        res.data = (res.kind == KIND_KEY || res.kind == KIND_VAL) ? row.data
                                                                                  : 8'h00;
                        res.last = (j == int'(row.n) - 1);
                        expect_q.push_back(res);
                    end
            end
        end
        settle();

        // Random buffers under several settings
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: settings = '{RST_IGNORE_A, RST_IGNORE_B, RST_IGNORE_C, RST_IGNORE_D,
                                RST_OPEN, RST_CLOSE, RST_KEY_DIV, RST_PAIR_DIV};
                1: settings = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h3D, 8'h3B};
                2: settings = '{8'h01, 8'h00, 8'h20, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFE};
                3: settings = '{8'h20, 8'h09, 8'h00, 8'h00, 8'h5B, 8'h3A, 8'h3A, 8'h2C};
                4: settings = '{8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h29, 8'h3D, 8'h2C};
                default:
                    foreach (settings[i])
                        settings[i] = ($urandom_range(3) == 0) ? 8'h00
                                                               : 8'($urandom_range(255));
            endcase
            // Swap the idle pattern every two phases, none at the end
            if (ph == 2)
            begin
                idle_pct  = 82;
                stall_pct = 31;
            end
            else if (ph == 4)
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            foreach (settings[i])
                write_reg(reg_index_t'(i), settings[i]);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                build_buffer();
                while (frame_q.size() != 0)
                begin
                    send_byte(frame_q[0], frame_q.size() == 1, 1'b1);
                    void'(frame_q.pop_front());
                    sent++;
                end
            end
            settle();
        end

        if (mismatches == 0)
            $display("framed_key_value_tokenizer_test: PASS");
        else
            $display("framed_key_value_tokenizer_test: FAIL");
        $finish;
    end

    // Result checker and receiver stall
    initial
    begin
        result_t want;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (expect_q.size() == 0)
                begin
                    $display("%0t ns: unexpected result kind %0d byte %h last %b",
                             $time, out_kind, out_byte, out_last);
                    mismatches++;
                end
                else
                begin
                    want = expect_q.pop_front();
                    if (out_kind !== want.kind)
                    begin
                        $display("%0t ns: out_kind expected %0d, got %0d",
                                 $time, want.kind, out_kind);
                        mismatches++;
                    end
                    if (out_byte !== want.data)
                    begin
                        $display("%0t ns: out_byte expected %h, got %h",
                                 $time, want.data, out_byte);
                        mismatches++;
                    end
                    if (out_last !== want.last)
                    begin
                        $display("%0t ns: out_last expected %b, got %b",
                                 $time, want.last, out_last);
                        mismatches++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Give up on a hung run
    initial
    begin
        #4_000_000;
        $display("framed_key_value_tokenizer_test: FAIL");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/ftk_pkg.sv
hdl/ftk_front.sv
hdl/ftk_queue.sv
hdl/ftk_back.sv
hdl/framed_key_value_tokenizer.sv
bench/framed_key_value_tokenizer_test.sv
